// ===== src/rpa_pkg.sv =====
// Package for the rectilinear polygon area block.
// Holds field widths, direction codes and the channel payload structs.
// No dependencies.
package rpa_pkg;

  localparam int COORD_BITS  = 24;
  localparam int LENGTH_BITS = 16;
  localparam int MOVE_BITS   = COORD_BITS + 2;
  localparam int OPND_BITS   = COORD_BITS + 1;
  localparam int CROSS_BITS  = 48;
  localparam int AREA_BITS   = 47;
  localparam int BOX_BITS    = 32;
  localparam int SCALE_BITS  = 8;
  localparam int COUNT_BITS  = 3;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(15);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = COUNT_BITS'(7);
  localparam logic [COUNT_BITS-1:0] MIN_SEGS    = COUNT_BITS'(4);

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef struct packed {
    dir_t        direction;
    logic [15:0] length;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]       area;
    logic signed [BOX_BITS-1:0] box_min_x;
    logic signed [BOX_BITS-1:0] box_min_y;
    logic [BOX_BITS-1:0]        box_width;
    logic [BOX_BITS-1:0]        box_height;
    logic                       overflow;
  } out_item_t;

endpackage

// ===== src/rectilinear_polygon_area.sv =====
// Rectilinear polygon area: shoelace accumulation over a stream of moves,
// with bounding box and sticky coordinate overflow. Uses rpa_pkg.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid in_ready in_data      | one move per transaction
//  out     | out_valid out_ready out_data   | one result per outline
//  cfg     | cfg_valid cfg_ready cfg_data   | box_scale write, always ready
//
// One move per cycle sustained unless a waiting result backs up the stages.
// The position/bbox update is a loop through its own registers; the cross term
// goes through an operand stage, a product stage and then the accumulator, and a
// result is registered at out_data once its last move has passed both stages.
// Stages hold their contents on a stall; moves keep flowing while a result
// waits as long as the stages ahead of the output are not full.
// Reset (rst_n low, synchronous) clears the outline state and sets box_scale
// to 15.
module rectilinear_polygon_area (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rpa_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rpa_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpa_pkg::SCALE_BITS-1:0]    cfg_data
);

  localparam int CB = rpa_pkg::COORD_BITS;
  localparam int MB = rpa_pkg::MOVE_BITS;
  localparam int OB = rpa_pkg::OPND_BITS;
  localparam int XB = rpa_pkg::CROSS_BITS;
  localparam int BB = rpa_pkg::BOX_BITS;
  localparam int SB = rpa_pkg::SCALE_BITS;
  localparam int NB = rpa_pkg::COUNT_BITS;
  localparam int LB = rpa_pkg::LENGTH_BITS;
  localparam int AB = rpa_pkg::AREA_BITS;

  // config
  logic [SB-1:0] scale_r;

  // outline state
  logic signed [CB-1:0] pos_x_r, pos_y_r, lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic signed [CB-1:0] pos_x_nxt, pos_y_nxt, lo_x_nxt, hi_x_nxt, lo_y_nxt, hi_y_nxt;
  logic [NB-1:0]        seg_r, seg_nxt;
  logic                 err_r, err_nxt;

  // operand stage
  logic                 s1_v_r, s1_last_r, s1_few_r, s1_err_r;
  logic signed [OB-1:0] s1_a_r, s1_b_r;
  logic signed [CB-1:0] s1_lo_x_r, s1_hi_x_r, s1_lo_y_r, s1_hi_y_r;

  // product stage
  logic                 s2_v_r, s2_last_r, s2_few_r, s2_err_r;
  logic [XB-1:0]        s2_prod_r;
  logic [BB-1:0]        s2_min_x_r, s2_min_y_r, s2_w_r, s2_h_r;

  // accumulator and output register
  logic [XB-1:0]        acc_r;
  logic                 out_v_r;
  rpa_pkg::out_item_t   out_q_r;

  // handshake
  logic in_go, s1_go, s2_go, out_free, s1_free, s2_free;

  assign out_free = !out_v_r || out_ready;
  assign s2_go    = s2_v_r && (!s2_last_r || out_free);
  assign s2_free  = !s2_v_r || s2_go;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_go;
  assign in_ready = s1_free;
  assign in_go    = in_valid && in_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_q_r;

  // ---------------- move and bbox update ----------------
  logic                 x_axis, neg, ovf;
  logic signed [MB-1:0] base, len_ext, sum;
  logic signed [CB-1:0] new_c, x1, y1;
  logic signed [OB-1:0] x0_e, y0_e, x1_e, y1_e, op_a, op_b;

  always_comb begin
    case (in_data.direction)
      rpa_pkg::DIR_RIGHT: begin x_axis = 1'b1; neg = 1'b0; end
      rpa_pkg::DIR_LEFT:  begin x_axis = 1'b1; neg = 1'b1; end
      rpa_pkg::DIR_UP:    begin x_axis = 1'b0; neg = 1'b1; end
      rpa_pkg::DIR_DOWN:  begin x_axis = 1'b0; neg = 1'b0; end
      default:            begin x_axis = 1'b1; neg = 1'b0; end
    endcase
    len_ext = signed'({{(MB-LB){1'b0}}, in_data.length[LB-1:0]});
    base    = x_axis ? {{(MB-CB){pos_x_r[CB-1]}}, pos_x_r}
                     : {{(MB-CB){pos_y_r[CB-1]}}, pos_y_r};
    sum     = neg ? base - len_ext : base + len_ext;
    // out of range unless the top bits are a plain sign extension
    ovf     = (sum[MB-1:CB-1] != '0) && (sum[MB-1:CB-1] != '1);
    new_c   = sum[CB-1:0];
    x1      = x_axis ? new_c : pos_x_r;
    y1      = x_axis ? pos_y_r : new_c;

    // axis-aligned edge: cross term is (x0-x1)*y0 or x0*(y1-y0)
    x0_e = {pos_x_r[CB-1], pos_x_r};
    y0_e = {pos_y_r[CB-1], pos_y_r};
    x1_e = {x1[CB-1], x1};
    y1_e = {y1[CB-1], y1};
    op_a = x_axis ? x0_e - x1_e : x0_e;
    op_b = x_axis ? y0_e : y1_e - y0_e;

    pos_x_nxt = x1;
    pos_y_nxt = y1;
    lo_x_nxt  = (x1 < lo_x_r) ? x1 : lo_x_r;
    hi_x_nxt  = (x1 > hi_x_r) ? x1 : hi_x_r;
    lo_y_nxt  = (y1 < lo_y_r) ? y1 : lo_y_r;
    hi_y_nxt  = (y1 > hi_y_r) ? y1 : hi_y_r;
    seg_nxt   = (seg_r == rpa_pkg::COUNT_MAX) ? seg_r : seg_r + 1'b1;
    err_nxt   = err_r | ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= rpa_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      lo_x_r  <= '0;
      hi_x_r  <= '0;
      lo_y_r  <= '0;
      hi_y_r  <= '0;
      seg_r   <= '0;
      err_r   <= 1'b0;
    end else if (in_go) begin
      if (in_data.last) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        lo_x_r  <= '0;
        hi_x_r  <= '0;
        lo_y_r  <= '0;
        hi_y_r  <= '0;
        seg_r   <= '0;
        err_r   <= 1'b0;
      end else begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        lo_x_r  <= lo_x_nxt;
        hi_x_r  <= hi_x_nxt;
        lo_y_r  <= lo_y_nxt;
        hi_y_r  <= hi_y_nxt;
        seg_r   <= seg_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // ---------------- operand stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_go) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_last_r <= in_data.last;
      s1_a_r    <= op_a;
      s1_b_r    <= op_b;
      s1_lo_x_r <= lo_x_nxt;
      s1_hi_x_r <= hi_x_nxt;
      s1_lo_y_r <= lo_y_nxt;
      s1_hi_y_r <= hi_y_nxt;
      s1_few_r  <= seg_nxt < rpa_pkg::MIN_SEGS;
      s1_err_r  <= err_nxt;
    end
  end

  // ---------------- product stage ----------------
  logic signed [2*OB-1:0] prod_full;
  logic [BB-1:0]          scale_w, lo_x_w, hi_x_w, lo_y_w, hi_y_w;

  always_comb begin
    prod_full = s1_a_r * s1_b_r;
    scale_w   = {{(BB-SB){1'b0}}, scale_r};
    lo_x_w    = {{(BB-CB){s1_lo_x_r[CB-1]}}, s1_lo_x_r};
    hi_x_w    = {{(BB-CB){s1_hi_x_r[CB-1]}}, s1_hi_x_r};
    lo_y_w    = {{(BB-CB){s1_lo_y_r[CB-1]}}, s1_lo_y_r};
    hi_y_w    = {{(BB-CB){s1_hi_y_r[CB-1]}}, s1_hi_y_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_go) begin
      s2_v_r <= 1'b1;
    end else if (s2_go) begin
      s2_v_r <= 1'b0;
    end
  end

  // box products wrap to 32 bits, same as the signed result's low bits
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_last_r  <= s1_last_r;
      s2_prod_r  <= prod_full[XB-1:0];
      s2_min_x_r <= lo_x_w * scale_w;
      s2_min_y_r <= lo_y_w * scale_w;
      s2_w_r     <= (hi_x_w - lo_x_w) * scale_w;
      s2_h_r     <= (hi_y_w - lo_y_w) * scale_w;
      s2_few_r   <= s1_few_r;
      s2_err_r   <= s1_err_r;
    end
  end

  // ---------------- accumulate and result ----------------
  logic [XB-1:0] mag;
  logic [AB-1:0] area;

  always_comb begin
    mag = acc_r[XB-1] ? (~acc_r + 1'b1) : acc_r;
    if (s2_few_r) begin
      area = '0;
    end else if (mag[XB-1]) begin
      area = '1;
    end else begin
      area = mag[AB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_go) begin
      // last move closes the outline: its term is dropped
      acc_r <= s2_last_r ? '0 : acc_r + s2_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_go && s2_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last_r) begin
      out_q_r.area       <= area;
      out_q_r.box_min_x  <= signed'(s2_min_x_r);
      out_q_r.box_min_y  <= signed'(s2_min_y_r);
      out_q_r.box_width  <= s2_w_r;
      out_q_r.box_height <= s2_h_r;
      out_q_r.overflow   <= s2_err_r;
    end
  end

endmodule

// ===== src/rpa_checker.sv =====
// Port-level checks for rectilinear_polygon_area, bound to the top level.
// Uses rpa_pkg for the payload types.
module rpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rpa_pkg::out_item_t out_data
);

  // result waits until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // with no result pending nothing can back up the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind rectilinear_polygon_area rpa_checker u_rpa_checker (.*);

// ===== dv/rpa_area_checker.sv =====
`timescale 1ns / 1ps
// Checker for rectilinear_polygon_area: watches the move, result and box_scale
// channels, predicts every outline result and compares it field by field.
// Depends on rpa_pkg.
module rpa_area_checker
  import rpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [SCALE_BITS-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due,
  output int                    outlines_checked
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam logic [CROSS_BITS-1:0] AREA_CAP = (CROSS_BITS'(1) << AREA_BITS) - 1;

  coord_t                pos_x, pos_y;
  coord_t                lo_x, hi_x, lo_y, hi_y;
  logic [CROSS_BITS-1:0] cross_acc;
  logic [COUNT_BITS-1:0] moves_seen;
  logic                  coord_ovf;
  logic [SCALE_BITS-1:0] box_scale;
  out_item_t             outline_q [$];

  task automatic clear_outline();
    pos_x      = '0;
    pos_y      = '0;
    lo_x       = '0;
    hi_x       = '0;
    lo_y       = '0;
    hi_y       = '0;
    cross_acc  = '0;
    moves_seen = '0;
    coord_ovf  = 1'b0;
  endtask

  task automatic take_move(in_item_t mv);
    coord_t                x0, y0, x1, y1;
    longint                len, nx, ny, term, s, prod;
    logic [CROSS_BITS-1:0] mag;
    out_item_t             res;
    x0  = pos_x;
    y0  = pos_y;
    len = longint'(mv.length[LENGTH_BITS-1:0]);
    nx  = longint'(x0);
    ny  = longint'(y0);
    case (mv.direction)
      DIR_RIGHT: nx = nx + len;
      DIR_LEFT:  nx = nx - len;
      DIR_UP:    ny = ny - len;
      DIR_DOWN:  ny = ny + len;
      default:   ;
    endcase
    // position wraps inside the coordinate width, flag stays set until the outline ends
    if (nx > COORD_HI || nx < COORD_LO || ny > COORD_HI || ny < COORD_LO)
      coord_ovf = 1'b1;
    x1 = nx[COORD_BITS-1:0];
    y1 = ny[COORD_BITS-1:0];

    if (x1 < lo_x) lo_x = x1;
    if (x1 > hi_x) hi_x = x1;
    if (y1 < lo_y) lo_y = y1;
    if (y1 > hi_y) hi_y = y1;
    if (moves_seen != COUNT_MAX) moves_seen = moves_seen + 1'b1;
    pos_x = x1;
    pos_y = y1;

    if (!mv.last) begin
      term      = longint'(x0) * longint'(y1) - longint'(x1) * longint'(y0);
      cross_acc = cross_acc + term[CROSS_BITS-1:0];
    end else begin
      // closing edge adds nothing; sum is read as two's complement
      mag = cross_acc[CROSS_BITS-1] ? -cross_acc : cross_acc;
      if (mag > AREA_CAP) mag = AREA_CAP;
      if (moves_seen < MIN_SEGS) mag = '0;
      s              = longint'(box_scale);
      res.area       = mag[AREA_BITS-1:0];
      prod           = longint'(lo_x) * s;
      res.box_min_x  = prod[BOX_BITS-1:0];
      prod           = longint'(lo_y) * s;
      res.box_min_y  = prod[BOX_BITS-1:0];
      prod           = (longint'(hi_x) - longint'(lo_x)) * s;
      res.box_width  = prod[BOX_BITS-1:0];
      prod           = (longint'(hi_y) - longint'(lo_y)) * s;
      res.box_height = prod[BOX_BITS-1:0];
      res.overflow   = coord_ovf;
      outline_q.push_back(res);
      clear_outline();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  task automatic compare_result();
    out_item_t want;
    if (outline_q.size() == 0) begin
      fail_count++;
      $display("%0t: result transaction with none expected, expected nothing, got %h",
               $time, out_data);
    end else begin
      want = outline_q.pop_front();
      outlines_checked++;
      check_field("area", 64'(want.area), 64'(out_data.area));
      check_field("box_min_x", 64'(want.box_min_x), 64'(out_data.box_min_x));
      check_field("box_min_y", 64'(want.box_min_y), 64'(out_data.box_min_y));
      check_field("box_width", 64'(want.box_width), 64'(out_data.box_width));
      check_field("box_height", 64'(want.box_height), 64'(out_data.box_height));
      check_field("overflow", 64'(want.overflow), 64'(out_data.overflow));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_outline();
      box_scale = SCALE_RESET;
      outline_q.delete();
    end else begin
      if (out_valid && out_ready) compare_result();
      if (cfg_valid && cfg_ready) box_scale = cfg_data;
      if (in_valid && in_ready) take_move(in_data);
    end
    results_due <= outline_q.size();
  end

endmodule

// ===== dv/tb_rectilinear_polygon_area.sv =====
`timescale 1ns / 1ps
// Top-level testbench for rectilinear_polygon_area: drives move outlines and
// box_scale writes, stalls the result side, and reports the verdict.
// Depends on rpa_pkg, rectilinear_polygon_area and rpa_area_checker.
module tb_rectilinear_polygon_area;
  import rpa_pkg::*;

  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_PCT       = 6;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_MOVES    = 40;
  localparam int OVF_RUN        = 129;
  localparam int TIMEOUT_NS     = 2_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [SCALE_BITS-1:0] cfg_data;

  int fail_count;
  int results_due;
  int outlines_checked;

  bit quiet         = 1'b0;
  int hold_requests = 0;
  int moves_sent    = 0;
  int scale_writes  = 0;
  int ovf_outlines  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rectilinear_polygon_area DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rpa_area_checker u_area_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .results_due      (results_due),
    .outlines_checked (outlines_checked)
  );

  // result side: random stalls, plus a long hold whenever the stimulus asks for one
  initial begin : rx_side
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic dir_t any_dir();
    return dir_t'($urandom_range(3));
  endfunction

  function automatic int unsigned any_length();
    return $urandom_range(1) ? $urandom_range(65535) : $urandom_range(255);
  endfunction

  task automatic send_move(dir_t d, int unsigned len, bit fin);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{direction: d, length: 16'(len), last: fin};
    do @(posedge clk); while (!in_ready);
    moves_sent++;
  endtask

  task automatic send_rect(int unsigned w, int unsigned h, bit ccw);
    if (ccw) begin
      send_move(DIR_DOWN, h, 1'b0);
      send_move(DIR_RIGHT, w, 1'b0);
      send_move(DIR_UP, h, 1'b0);
      send_move(DIR_LEFT, w, 1'b1);
    end else begin
      send_move(DIR_RIGHT, w, 1'b0);
      send_move(DIR_DOWN, h, 1'b0);
      send_move(DIR_LEFT, w, 1'b0);
      send_move(DIR_UP, h, 1'b1);
    end
  endtask

  task automatic send_staircase();
    int unsigned steps, run_w, run_h;
    int unsigned w [4];
    int unsigned h [4];
    steps = $urandom_range(1, 4);
    run_w = 0;
    run_h = 0;
    for (int i = 0; i < steps; i++) begin
      w[i]  = $urandom_range(1, 16383);
      h[i]  = $urandom_range(1, 16383);
      run_w += w[i];
      run_h += h[i];
    end
    send_move(DIR_RIGHT, run_w, 1'b0);
    for (int i = 0; i < steps; i++) begin
      send_move(DIR_DOWN, h[i], 1'b0);
      send_move(DIR_LEFT, w[i], 1'b0);
    end
    send_move(DIR_UP, run_h, 1'b1);
  endtask

  // open or self-crossing outlines with arbitrary moves
  task automatic send_scribble(int unsigned n);
    for (int i = 0; i < n; i++)
      send_move(any_dir(), any_length(), i == n - 1);
  endtask

  // walk far enough in one direction to leave the coordinate range
  task automatic send_runaway(dir_t d);
    repeat (OVF_RUN) send_move(d, 65535, 1'b0);
    send_move(any_dir(), any_length(), 1'b1);
    ovf_outlines++;
  endtask

  task automatic send_random_outline();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)
      send_rect(any_length(), any_length(), 1'($urandom_range(1)));
    else if (pick < 60)
      send_staircase();
    else if (pick < 80)
      send_scribble($urandom_range(1, 12));
    else if (pick < 90)
      send_scribble($urandom_range(1, 3));
    else
      send_rect($urandom_range(1) ? 65535 : 0, $urandom_range(1) ? 65535 : 0,
                1'($urandom_range(1)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_box_scale(logic [SCALE_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_writes++;
  endtask

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_rectilinear_polygon_area: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [SCALE_BITS-1:0] scale_plan [5];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    scale_plan[0] = 8'd1;
    scale_plan[1] = 8'd255;
    scale_plan[2] = 8'd0;
    scale_plan[3] = 8'($urandom_range(2, 254));
    scale_plan[4] = 8'($urandom_range(2, 254));
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed outlines at the reset scale
    send_rect(16, 32, 1'b0);
    send_rect(65535, 65535, 1'b1);
    send_move(DIR_LEFT, 65535, 1'b1);
    send_move(DIR_UP, 0, 1'b0);
    send_move(DIR_RIGHT, 1, 1'b0);
    send_move(DIR_DOWN, 65535, 1'b1);
    send_move(DIR_RIGHT, 40000, 1'b0);
    send_move(DIR_DOWN, 30000, 1'b0);
    send_move(DIR_LEFT, 20000, 1'b0);
    send_move(DIR_UP, 10000, 1'b0);
    send_move(DIR_LEFT, 20000, 1'b0);
    send_move(DIR_UP, 20000, 1'b1);
    // more than seven moves: segment count saturates
    send_move(DIR_RIGHT, 100, 1'b0);
    send_move(DIR_DOWN, 100, 1'b0);
    send_move(DIR_RIGHT, 100, 1'b0);
    send_move(DIR_DOWN, 100, 1'b0);
    send_move(DIR_LEFT, 200, 1'b0);
    send_move(DIR_UP, 50, 1'b0);
    send_move(DIR_LEFT, 0, 1'b0);
    send_move(DIR_UP, 150, 1'b1);

    for (int p = 0; p < 5; p++) begin
      int target;
      drain_results();
      write_box_scale(scale_plan[p]);
      if (p == 0) quiet = 1'b1;
      if (p == 1) send_runaway(DIR_UP);
      if (p == 4) send_runaway(DIR_RIGHT);
      if (p == 3) begin
        // hold the result side while short outlines keep coming, then let it all drain
        hold_requests++;
        repeat (40) send_move(any_dir(), any_length(), 1'b1);
        drain_results();
      end
      target = moves_sent + PHASE_MOVES;
      while (moves_sent < target) begin
        if (p == 0 && moves_sent + PHASE_MOVES / 2 >= target) quiet = 1'b0;
        send_random_outline();
      end
      quiet = 1'b0;
    end

    drain_results();
    $display("tb_rectilinear_polygon_area: %0d moves, %0d outlines checked, %0d box_scale writes",
             moves_sent, outlines_checked, scale_writes);
    $display("tb_rectilinear_polygon_area: %0d overflow outlines, scales 0/1/255, %0d-cycle stall",
             ovf_outlines, RX_HOLD_CYCLES);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb_rectilinear_polygon_area: done, clean");
    end else begin
      $display("tb_rectilinear_polygon_area: done, errors");
    end
    $finish;
  end

endmodule
